@@ sv/qat_pkg.sv @@
package qat_pkg;

	// Width of one packed quaternion component and of one coordinate port.
	localparam int QCOMP_W = 16;
	localparam int FIELD_W = 32;

	// Number of spatial axes handled by the transform.
	localparam int AXES = 3;

	// A signed coordinate word as it appears on the ports.
	typedef logic signed [FIELD_W-1:0] field_t;

	// A signed quaternion component.
	typedef logic signed [QCOMP_W-1:0] qcomp_t;

endpackage

@@ sv/quaternion_aabb_transform.sv @@
// A word accepted with start passes through the stage registers s1 to s5 and appears on the world ports,
// marked by done; done stays high for exactly one cycle.
// Throughput: one word per cycle, every cycle, set by the five-stage pipeline
// (quaternion products, matrix rounding, term multipliers, min/max pick, axis sum).
// The receiver cannot stall, so busy is always low.
// Reset (arst_n low) clears the pipeline valid bits at once; data registers keep no reset.
module quaternion_aabb_transform import qat_pkg::*; #(
	parameter int COORD_WIDTH    = 32,
	parameter int QUAT_FRAC_BITS = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [63:0]          rotation,
	input  field_t               position_x,
	input  field_t               position_y,
	input  field_t               position_z,
	input  field_t               local_min_x,
	input  field_t               local_min_y,
	input  field_t               local_min_z,
	input  field_t               local_max_x,
	input  field_t               local_max_y,
	input  field_t               local_max_z,
	output logic                 done,
	output field_t               world_min_x,
	output field_t               world_min_y,
	output field_t               world_min_z,
	output field_t               world_max_x,
	output field_t               world_max_y,
	output field_t               world_max_z
);

	localparam int CW    = COORD_WIDTH;
	localparam int F     = QUAT_FRAC_BITS;
	localparam int PRODW = 2 * QCOMP_W;
	localparam int EW    = PRODW + 4;
	localparam int RW    = EW - F;
	localparam int MW    = F + 2;
	localparam int TPW   = MW + CW;
	localparam int TW    = TPW - F;
	localparam int SW    = CW + 4;

	localparam logic signed [EW-1:0]  E_ONE  = EW'(64'd1 << (2 * F));
	localparam logic signed [EW-1:0]  E_HALF = EW'(64'd1 << (F - 1));
	localparam logic signed [RW-1:0]  R_LIM  = RW'((64'd1 << (F + 1)) - 64'd1);
	localparam logic signed [RW-1:0]  R_NLIM = -R_LIM;
	localparam logic signed [TPW-1:0] T_HALF = TPW'(64'd1 << (F - 1));
	localparam logic signed [SW-1:0]  S_MAX  = SW'((64'd1 << (CW - 1)) - 64'd1);
	localparam logic signed [SW-1:0]  S_MIN  = ~S_MAX;

	// Reads a port word as a CW-bit two's complement coordinate.
	// Bits above the port word are zero, so a CW wider than the port word never sees a sign bit.
	function automatic logic signed [CW-1:0] to_coord(input field_t v);
		logic signed [63:0] w;
		w = {{(64-FIELD_W){1'b0}}, v};
		return w[CW-1:0];
	endfunction

	// Rounds a matrix entry half up to F fraction bits and clamps it below magnitude two.
	function automatic logic signed [MW-1:0] round_entry(input logic signed [EW-1:0] e);
		logic signed [EW-1:0] t;
		logic signed [RW-1:0] r;
		t = e + E_HALF;
		r = RW'(t >>> F);
		if (r > R_LIM) begin
			r = R_LIM;
		end else if (r < R_NLIM) begin
			r = R_NLIM;
		end
		return MW'(r);
	endfunction

	// Rounds a matrix-by-coordinate product back to the coordinate format.
	function automatic logic signed [TW-1:0] round_term(input logic signed [TPW-1:0] p);
		logic signed [TPW-1:0] t;
		t = p + T_HALF;
		return TW'(t >>> F);
	endfunction

	// Saturates an axis sum to CW bits and places it on a port word.
	function automatic field_t to_field(input logic signed [SW-1:0] s);
		logic signed [CW-1:0] c;
		logic signed [63:0]   w;
		if (s > S_MAX) begin
			c = S_MAX[CW-1:0];
		end else if (s < S_MIN) begin
			c = S_MIN[CW-1:0];
		end else begin
			c = s[CW-1:0];
		end
		w = 64'(c);
		return w[FIELD_W-1:0];
	endfunction

	// The pipeline never stalls, so the block is always ready for a word.
	assign busy = 1'b0;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// Valid bits travel alongside the data through every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: the nine quaternion component products and the unpacked coordinates.
	qcomp_t qx, qy, qz, qw;
	assign qx = rotation[15:0];
	assign qy = rotation[31:16];
	assign qz = rotation[47:32];
	assign qw = rotation[63:48];

	logic signed [PRODW-1:0] xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	logic signed [CW-1:0]    pos_s1 [AXES];
	logic signed [CW-1:0]    cmin_s1 [AXES];
	logic signed [CW-1:0]    cmax_s1 [AXES];

	always_ff @(posedge clk) begin
		xx_s1      <= qx * qx;
		yy_s1      <= qy * qy;
		zz_s1      <= qz * qz;
		xy_s1      <= qx * qy;
		xz_s1      <= qx * qz;
		yz_s1      <= qy * qz;
		wx_s1      <= qw * qx;
		wy_s1      <= qw * qy;
		wz_s1      <= qw * qz;
		pos_s1[0]  <= to_coord(position_x);
		pos_s1[1]  <= to_coord(position_y);
		pos_s1[2]  <= to_coord(position_z);
		cmin_s1[0] <= to_coord(local_min_x);
		cmin_s1[1] <= to_coord(local_min_y);
		cmin_s1[2] <= to_coord(local_min_z);
		cmax_s1[0] <= to_coord(local_max_x);
		cmax_s1[1] <= to_coord(local_max_y);
		cmax_s1[2] <= to_coord(local_max_z);
	end

	// Stage 2: exact matrix entries, then rounding and clamping of each one.
	logic signed [EW-1:0] ent [9];

	always_comb begin
		ent[0] = E_ONE - ((EW'(yy_s1) + EW'(zz_s1)) <<< 1);
		ent[1] = (EW'(xy_s1) - EW'(wz_s1)) <<< 1;
		ent[2] = (EW'(xz_s1) + EW'(wy_s1)) <<< 1;
		ent[3] = (EW'(xy_s1) + EW'(wz_s1)) <<< 1;
		ent[4] = E_ONE - ((EW'(xx_s1) + EW'(zz_s1)) <<< 1);
		ent[5] = (EW'(yz_s1) - EW'(wx_s1)) <<< 1;
		ent[6] = (EW'(xz_s1) - EW'(wy_s1)) <<< 1;
		ent[7] = (EW'(yz_s1) + EW'(wx_s1)) <<< 1;
		ent[8] = E_ONE - ((EW'(xx_s1) + EW'(yy_s1)) <<< 1);
	end

	logic signed [MW-1:0] m_s2 [9];
	logic signed [CW-1:0] pos_s2 [AXES];
	logic signed [CW-1:0] cmin_s2 [AXES];
	logic signed [CW-1:0] cmax_s2 [AXES];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			m_s2[k] <= round_entry(ent[k]);
		end
		pos_s2  <= pos_s1;
		cmin_s2 <= cmin_s1;
		cmax_s2 <= cmax_s1;
	end

	// Stage 3: each matrix entry times the matching minimum and maximum coordinate.
	logic signed [TPW-1:0] pmin_s3 [9];
	logic signed [TPW-1:0] pmax_s3 [9];
	logic signed [CW-1:0]  pos_s3 [AXES];

	always_ff @(posedge clk) begin
		for (int i = 0; i < AXES; i++) begin
			for (int j = 0; j < AXES; j++) begin
				pmin_s3[i*AXES+j] <= m_s2[i*AXES+j] * cmin_s2[j];
				pmax_s3[i*AXES+j] <= m_s2[i*AXES+j] * cmax_s2[j];
			end
		end
		pos_s3 <= pos_s2;
	end

	// Stage 4: round both products and send the smaller to the low side.
	logic signed [TW-1:0] ta [9];
	logic signed [TW-1:0] tb [9];

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			ta[k] = round_term(pmin_s3[k]);
			tb[k] = round_term(pmax_s3[k]);
		end
	end

	logic signed [TW-1:0] lo_s4 [9];
	logic signed [TW-1:0] hi_s4 [9];
	logic signed [CW-1:0] pos_s4 [AXES];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			if (ta[k] < tb[k]) begin
				lo_s4[k] <= ta[k];
				hi_s4[k] <= tb[k];
			end else begin
				lo_s4[k] <= tb[k];
				hi_s4[k] <= ta[k];
			end
		end
		pos_s4 <= pos_s3;
	end

	// Stage 5: position plus the three terms of each axis, saturated.
	logic signed [SW-1:0] lo_sum [AXES];
	logic signed [SW-1:0] hi_sum [AXES];

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			lo_sum[i] = SW'(pos_s4[i]) + SW'(lo_s4[i*AXES]) + SW'(lo_s4[i*AXES+1])
				+ SW'(lo_s4[i*AXES+2]);
			hi_sum[i] = SW'(pos_s4[i]) + SW'(hi_s4[i*AXES]) + SW'(hi_s4[i*AXES+1])
				+ SW'(hi_s4[i*AXES+2]);
		end
	end

	field_t wmin_s5 [AXES];
	field_t wmax_s5 [AXES];

	always_ff @(posedge clk) begin
		for (int i = 0; i < AXES; i++) begin
			wmin_s5[i] <= to_field(lo_sum[i]);
			wmax_s5[i] <= to_field(hi_sum[i]);
		end
	end

	// Result word and its one-cycle strobe.
	assign done        = v_s5;
	assign world_min_x = wmin_s5[0];
	assign world_min_y = wmin_s5[1];
	assign world_min_z = wmin_s5[2];
	assign world_max_x = wmax_s5[0];
	assign world_max_y = wmax_s5[1];
	assign world_max_z = wmax_s5[2];

endmodule

@@ sv/qat_checker.sv @@
module qat_checker import qat_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   start,
	input logic   busy,
	input logic   done,
	input field_t world_min_x,
	input field_t world_min_y,
	input field_t world_min_z,
	input field_t world_max_x,
	input field_t world_max_y,
	input field_t world_max_z
);

	// The pipeline has no stall path, so it never refuses a word.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised although the pipeline cannot stall");

	// Every accepted word yields its result, marked by done.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("accepted word produced no result after five cycles");

	// No result appears without a matching accepted word.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 5))
		else $error("result strobe without a matching accepted word");

	// Each per-entry min/max pick and the saturation keep the box well ordered.
	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (world_min_x <= world_max_x) && (world_min_y <= world_max_y)
			&& (world_min_z <= world_max_z))
		else $error("world box minimum lies above its maximum");

endmodule

bind quaternion_aabb_transform qat_checker u_qat_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.world_min_x (world_min_x),
	.world_min_y (world_min_y),
	.world_min_z (world_min_z),
	.world_max_x (world_max_x),
	.world_max_y (world_max_y),
	.world_max_z (world_max_z)
);

@@ tb/sv/aabb_box_checker.sv @@
// Watches the object and result channels of the box transform, predicts each
// world box and compares it with what the block returns.
module aabb_box_checker import qat_pkg::*; #(
	parameter int COORD_WIDTH    = 32,
	parameter int QUAT_FRAC_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [63:0] rotation,
	input  field_t      position_x,
	input  field_t      position_y,
	input  field_t      position_z,
	input  field_t      local_min_x,
	input  field_t      local_min_y,
	input  field_t      local_min_z,
	input  field_t      local_max_x,
	input  field_t      local_max_y,
	input  field_t      local_max_z,
	input  logic        done,
	input  field_t      world_min_x,
	input  field_t      world_min_y,
	input  field_t      world_min_z,
	input  field_t      world_max_x,
	input  field_t      world_max_y,
	input  field_t      world_max_z,
	output int          fail_count,
	output int          waiting
);

	typedef struct packed {
		field_t min_x;
		field_t min_y;
		field_t min_z;
		field_t max_x;
		field_t max_y;
		field_t max_z;
	} world_box_t;

	// World boxes predicted for accepted objects, oldest first.
	world_box_t expected_boxes[$];
	world_box_t want;
	int         result_index;

	initial begin
		fail_count   = 0;
		waiting      = 0;
		result_index = 0;
	end

	// Only the low COORD_WIDTH bits of a coordinate word count, as two's complement.
	function automatic longint coord_value(field_t v);
		longint raw;
		raw = {32'd0, v};
		return (raw <<< (64 - COORD_WIDTH)) >>> (64 - COORD_WIDTH);
	endfunction

	// Drops s fraction bits, rounding half up; the arithmetic shift floors.
	function automatic longint round_half_up(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Rotation matrix from the quaternion, then the min/max pick per matrix entry.
	function automatic world_box_t rotate_box(logic [63:0] rot,
			field_t px, field_t py, field_t pz,
			field_t nx, field_t ny, field_t nz,
			field_t xx, field_t xy, field_t xz);
		longint     q_x, q_y, q_z, q_w;
		longint     one, lim, cmax, cmin, lo, hi, a, b;
		longint     e [9];
		longint     m [9];
		longint     pos [3];
		longint     cmn [3];
		longint     cmx [3];
		longint     wmin [3];
		longint     wmax [3];
		int         i, j;
		world_box_t box;

		q_x = longint'($signed(rot[15:0]));
		q_y = longint'($signed(rot[31:16]));
		q_z = longint'($signed(rot[47:32]));
		q_w = longint'($signed(rot[63:48]));
		one = longint'(1) <<< (2 * QUAT_FRAC_BITS);

		e[0] = one - 2 * (q_y * q_y + q_z * q_z);
		e[1] = 2 * (q_x * q_y - q_w * q_z);
		e[2] = 2 * (q_x * q_z + q_w * q_y);
		e[3] = 2 * (q_x * q_y + q_w * q_z);
		e[4] = one - 2 * (q_x * q_x + q_z * q_z);
		e[5] = 2 * (q_y * q_z - q_w * q_x);
		e[6] = 2 * (q_x * q_z - q_w * q_y);
		e[7] = 2 * (q_y * q_z + q_w * q_x);
		e[8] = one - 2 * (q_x * q_x + q_y * q_y);

		// Entries of a non-unit quaternion are held just under magnitude 2.0.
		lim = (longint'(1) <<< (QUAT_FRAC_BITS + 1)) - 1;
		for (i = 0; i < 9; i++)
			m[i] = clamp(round_half_up(e[i], QUAT_FRAC_BITS), -lim, lim);

		pos[0] = coord_value(px);
		pos[1] = coord_value(py);
		pos[2] = coord_value(pz);
		cmn[0] = coord_value(nx);
		cmn[1] = coord_value(ny);
		cmn[2] = coord_value(nz);
		cmx[0] = coord_value(xx);
		cmx[1] = coord_value(xy);
		cmx[2] = coord_value(xz);
		cmax   = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
		cmin   = -cmax - 1;

		// The smaller term goes to the minimum, so inverted boxes come out as if swapped.
		for (i = 0; i < 3; i++) begin
			lo = pos[i];
			hi = pos[i];
			for (j = 0; j < 3; j++) begin
				a = round_half_up(m[i * 3 + j] * cmn[j], QUAT_FRAC_BITS);
				b = round_half_up(m[i * 3 + j] * cmx[j], QUAT_FRAC_BITS);
				if (a < b) begin
					lo += a;
					hi += b;
				end else begin
					lo += b;
					hi += a;
				end
			end
			wmin[i] = clamp(lo, cmin, cmax);
			wmax[i] = clamp(hi, cmin, cmax);
		end

		box.min_x = field_t'(wmin[0]);
		box.min_y = field_t'(wmin[1]);
		box.min_z = field_t'(wmin[2]);
		box.max_x = field_t'(wmax[0]);
		box.max_y = field_t'(wmax[1]);
		box.max_z = field_t'(wmax[2]);
		return box;
	endfunction

	task automatic report_fail(string msg);
		$display("MISMATCH at result %0d: %s", result_index, msg);
		fail_count++;
	endtask

	task automatic check_field(string name, field_t got, field_t exp_val);
		if (got !== exp_val)
			report_fail($sformatf("%s got %0d (%h) expected %0d (%h)",
				name, got, got, exp_val, exp_val));
	endtask

	// Results are compared before the word of the same edge is queued,
	// since a registered result can never belong to that word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done !== 1'b0) begin
				if (expected_boxes.size() == 0) begin
					report_fail("result with no object waiting");
				end else begin
					want = expected_boxes.pop_front();
					check_field("world_min_x", world_min_x, want.min_x);
					check_field("world_min_y", world_min_y, want.min_y);
					check_field("world_min_z", world_min_z, want.min_z);
					check_field("world_max_x", world_max_x, want.max_x);
					check_field("world_max_y", world_max_y, want.max_y);
					check_field("world_max_z", world_max_z, want.max_z);
				end
				result_index++;
			end
			if (start === 1'b1 && busy === 1'b0)
				expected_boxes.push_back(rotate_box(rotation,
					position_x, position_y, position_z,
					local_min_x, local_min_y, local_min_z,
					local_max_x, local_max_y, local_max_z));
			waiting = expected_boxes.size();
		end
	end

endmodule

@@ tb/sv/tb_top.sv @@
// Drives objects into the box transform with random gaps; the checker beside
// the block predicts and compares every world box.
module tb_top;
	import qat_pkg::*;

	// Quaternions are packed {w, z, y, x}, Q1.14.
	localparam logic [63:0] ROT_IDENTITY = {16'h4000, 16'h0000, 16'h0000, 16'h0000};
	localparam logic [63:0] ROT_Z90      = {16'h2D41, 16'h2D41, 16'h0000, 16'h0000};
	localparam logic [63:0] ROT_Y90      = {16'h2D41, 16'h0000, 16'h2D41, 16'h0000};
	localparam logic [63:0] ROT_X180     = {16'h0000, 16'h0000, 16'h0000, 16'h4000};
	localparam logic [63:0] ROT_NEG_W    = {16'hC000, 16'h0000, 16'h0000, 16'h0000};
	localparam logic [63:0] ROT_ZERO     = 64'h0;
	localparam logic [63:0] ROT_ALL_MAX  = {4{16'h7FFF}};
	localparam logic [63:0] ROT_ALL_MIN  = {4{16'h8000}};
	localparam logic [63:0] ROT_ALL_ONES = {4{16'hFFFF}};

	localparam field_t C_ONE  = 32'sh0001_0000;
	localparam field_t C_HALF = 32'sh0000_8000;
	localparam field_t C_MAX  = 32'sh7FFF_FFFF;
	localparam field_t C_MIN  = 32'sh8000_0000;

	localparam int RANDOM_OBJECTS = 1400;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        start  = 1'b0;
	logic        busy;
	logic [63:0] rotation    = '0;
	field_t      position_x  = '0;
	field_t      position_y  = '0;
	field_t      position_z  = '0;
	field_t      local_min_x = '0;
	field_t      local_min_y = '0;
	field_t      local_min_z = '0;
	field_t      local_max_x = '0;
	field_t      local_max_y = '0;
	field_t      local_max_z = '0;
	logic        done;
	field_t      world_min_x, world_min_y, world_min_z;
	field_t      world_max_x, world_max_y, world_max_z;
	int          fail_count;
	int          boxes_waiting;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	quaternion_aabb_transform DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.rotation    (rotation),
		.position_x  (position_x),
		.position_y  (position_y),
		.position_z  (position_z),
		.local_min_x (local_min_x),
		.local_min_y (local_min_y),
		.local_min_z (local_min_z),
		.local_max_x (local_max_x),
		.local_max_y (local_max_y),
		.local_max_z (local_max_z),
		.done        (done),
		.world_min_x (world_min_x),
		.world_min_y (world_min_y),
		.world_min_z (world_min_z),
		.world_max_x (world_max_x),
		.world_max_y (world_max_y),
		.world_max_z (world_max_z)
	);

	aabb_box_checker box_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.rotation    (rotation),
		.position_x  (position_x),
		.position_y  (position_y),
		.position_z  (position_z),
		.local_min_x (local_min_x),
		.local_min_y (local_min_y),
		.local_min_z (local_min_z),
		.local_max_x (local_max_x),
		.local_max_y (local_max_y),
		.local_max_z (local_max_z),
		.done        (done),
		.world_min_x (world_min_x),
		.world_min_y (world_min_y),
		.world_min_z (world_min_z),
		.world_max_x (world_max_x),
		.world_max_y (world_max_y),
		.world_max_z (world_max_z),
		.fail_count  (fail_count),
		.waiting     (boxes_waiting)
	);

	// Puts one object word on the ports and holds it until the block takes it.
	// Start stays high on return so back-to-back words need no extra edge.
	task automatic drive_object(logic [63:0] rot,
			field_t px, field_t py, field_t pz,
			field_t nx, field_t ny, field_t nz,
			field_t xx, field_t xy, field_t xz);
		@(negedge clk);
		start       <= 1'b1;
		rotation    <= rot;
		position_x  <= px;
		position_y  <= py;
		position_z  <= pz;
		local_min_x <= nx;
		local_min_y <= ny;
		local_min_z <= nz;
		local_max_x <= xx;
		local_max_y <= xy;
		local_max_z <= xz;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	// Idle cycles with start low and junk on the data ports.
	task automatic idle_cycles(int n);
		repeat (n) begin
			@(negedge clk);
			start       <= 1'b0;
			rotation    <= {$urandom, $urandom};
			position_x  <= $urandom;
			position_y  <= $urandom;
			position_z  <= $urandom;
			local_min_x <= $urandom;
			local_min_y <= $urandom;
			local_min_z <= $urandom;
			local_max_x <= $urandom;
			local_max_y <= $urandom;
			local_max_z <= $urandom;
		end
	endtask

	// Mostly short gaps, now and then a long one.
	function automatic int random_gap();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic field_t random_coord();
		case ($urandom_range(0, 9))
			0: return C_MAX;
			1: return C_MIN;
			2, 3: return field_t'($urandom);
			4: return field_t'(int'($urandom_range(0, 16)) - 8);
			default: return field_t'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
		endcase
	endfunction

	function automatic qcomp_t random_qcomp();
		case ($urandom_range(0, 11))
			0: return 16'sh4000;
			1: return -16'sh4000;
			2: return 16'sh2D41;
			3: return -16'sh2D41;
			4: return 16'sh7FFF;
			5: return 16'sh8000;
			6: return 16'sh0000;
			7, 8: return qcomp_t'($urandom);
			default: return qcomp_t'(int'($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	// Most boxes are well formed (min not above max); the rest are left as drawn.
	task automatic send_random_object();
		logic [63:0] rot;
		field_t      lo [3];
		field_t      hi [3];
		field_t      tmp;
		bit          ordered;
		int          k;

		if ($urandom_range(0, 7) == 0)
			rot = {$urandom, $urandom};
		else
			rot = {random_qcomp(), random_qcomp(), random_qcomp(), random_qcomp()};
		ordered = ($urandom_range(0, 9) < 7);
		for (k = 0; k < 3; k++) begin
			lo[k] = random_coord();
			hi[k] = random_coord();
			if (ordered && lo[k] > hi[k]) begin
				tmp   = lo[k];
				lo[k] = hi[k];
				hi[k] = tmp;
			end
		end
		drive_object(rot, random_coord(), random_coord(), random_coord(),
			lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
	endtask

	initial begin
		int  n;
		bit  quiet;

		quiet = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed words: known rotations, degenerate quaternions and coordinate extremes.
		drive_object(ROT_IDENTITY, C_ONE, 2 * C_ONE, 3 * C_ONE,
			-C_ONE, -C_ONE, -C_ONE, C_ONE, C_ONE, C_ONE);
		drive_object(ROT_Z90, '0, '0, '0,
			-2 * C_ONE, -C_ONE, -C_HALF, 3 * C_ONE, C_ONE, C_HALF);
		drive_object(ROT_X180, C_HALF, -C_HALF, C_ONE,
			-2 * C_ONE, -C_ONE, -C_HALF, 3 * C_ONE, C_ONE, C_HALF);
		drive_object(ROT_Y90, -C_ONE, C_ONE, '0,
			-C_ONE, 5 * C_ONE, -7 * C_ONE, C_HALF, 6 * C_ONE, -C_HALF);
		idle_cycles(3);
		drive_object(ROT_ZERO, C_ONE, C_ONE, C_ONE,
			-C_ONE, -C_ONE, -C_ONE, C_ONE, C_ONE, C_ONE);
		drive_object(ROT_ALL_MAX, '0, '0, '0,
			-C_ONE, -2 * C_ONE, -3 * C_ONE, C_ONE, 2 * C_ONE, 3 * C_ONE);
		drive_object(ROT_ALL_MIN, '0, '0, '0,
			-C_ONE, -2 * C_ONE, -3 * C_ONE, C_ONE, 2 * C_ONE, 3 * C_ONE);
		drive_object(ROT_ALL_ONES, C_ONE, '0, -C_ONE,
			-C_ONE, -C_ONE, -C_ONE, C_ONE, C_ONE, C_ONE);
		drive_object(ROT_NEG_W, C_ONE, 2 * C_ONE, 3 * C_ONE,
			-C_ONE, -C_HALF, '0, C_ONE, C_HALF, C_ONE);
		// Inverted box: each min corner lies above its max.
		drive_object(ROT_Z90, '0, '0, '0,
			3 * C_ONE, C_ONE, C_HALF, -2 * C_ONE, -C_ONE, -C_HALF);
		// Point box: both corners give the same product.
		drive_object(ROT_Y90, C_ONE, C_ONE, C_ONE,
			C_HALF, -C_ONE, 2 * C_ONE, C_HALF, -C_ONE, 2 * C_ONE);
		// Saturation at both ends of the coordinate range.
		drive_object(ROT_IDENTITY, C_MAX, C_MAX, C_MAX,
			C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
		drive_object(ROT_IDENTITY, C_MIN, C_MIN, C_MIN,
			C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
		drive_object(ROT_ALL_MAX, C_MAX, C_MIN, C_MAX,
			C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
		drive_object(ROT_ALL_MIN, C_MIN, C_MAX, C_MIN,
			C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
		drive_object(ROT_X180, '0, '0, '0,
			C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
		// Tiny coordinates exercise the half-up rounding of each term.
		drive_object(ROT_Z90, 32'sd1, -32'sd1, '0,
			-32'sd1, -32'sd3, 32'sd1, 32'sd1, 32'sd3, 32'sd2);
		drive_object(ROT_Y90, '0, '0, '0,
			-32'sd2, 32'sd1, -32'sd5, 32'sd2, 32'sd7, 32'sd5);
		drive_object({$urandom, $urandom}, C_ONE, C_ONE, C_ONE,
			'0, '0, '0, '0, '0, '0);

		// Random words; some stretches run with no gaps at all.
		for (n = 0; n < RANDOM_OBJECTS; n++) begin
			if (n % 200 == 0)
				quiet = ($urandom_range(0, 2) == 0);
			if (!quiet && $urandom_range(0, 3) == 0)
				idle_cycles(random_gap());
			send_random_object();
		end

		@(negedge clk);
		start <= 1'b0;
		while (boxes_waiting != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog against a hung handshake or missing results.
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/qat_pkg.sv
sv/quaternion_aabb_transform.sv
sv/qat_checker.sv
tb/sv/aabb_box_checker.sv
tb/sv/tb_top.sv
